// File: rtl/tbe_pkg.sv
package tbe_pkg;

  // Event codes as they appear on the result stream.
  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_PUSH1 = 3'd1,
    EV_PUSH2 = 3'd2,
    EV_LONG1 = 3'd3,
    EV_LONG2 = 3'd4,
    EV_LREL1 = 3'd5,
    EV_LREL2 = 3'd6,
    EV_BOTH  = 3'd7
  } evt_t;

  typedef enum logic [6:0] {
    ST_INIT      = 7'b0000001,
    ST_WAIT_PUSH = 7'b0000010,
    ST_SW1_WAIT  = 7'b0000100,
    ST_SW2_WAIT  = 7'b0001000,
    ST_SW1_LONG  = 7'b0010000,
    ST_SW2_LONG  = 7'b0100000,
    ST_BOTH      = 7'b1000000
  } state_t;

  localparam int unsigned HOLD_W = 16;

  // Register word indexes on the configuration port.
  localparam logic REG_LONG_PRESS_TICKS = 1'b0;
  localparam logic [HOLD_W-1:0] LONG_PRESS_TICKS_RESET = 16'd100;

  // One sample tick as seen by the detector.
  typedef struct packed {
    logic              tick;
    logic              sw1_pressed;
    logic              sw2_pressed;
    logic [HOLD_W-1:0] long_press_ticks;
  } tick_req_t;

endpackage

// File: rtl/tbe_detector.sv
module tbe_detector (
  input  logic               clk,
  input  logic               rst,
  input  tbe_pkg::tick_req_t req,
  output tbe_pkg::evt_t      ev
);
  import tbe_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [2:0]        sw1_history;
  logic [2:0]        sw2_history;
  logic [2:0]        sw1_history_next;
  logic [2:0]        sw2_history_next;
  logic [HOLD_W-1:0] sw1_hold_left;
  logic [HOLD_W-1:0] sw2_hold_left;
  logic [HOLD_W-1:0] sw1_hold_left_next;
  logic [HOLD_W-1:0] sw2_hold_left_next;

  // Bit 0 of each history is the newest sample.
  assign sw1_history_next = {sw1_history[1:0], req.sw1_pressed};
  assign sw2_history_next = {sw2_history[1:0], req.sw2_pressed};

  always_comb begin
    state_next         = state;
    sw1_hold_left_next = sw1_hold_left;
    sw2_hold_left_next = sw2_hold_left;
    ev                 = EV_NONE;
    case (state)
      ST_WAIT_PUSH: begin
        if (sw1_history_next == 3'b011) begin
          state_next         = ST_SW1_WAIT;
          sw1_hold_left_next = req.long_press_ticks;
        end else if (sw2_history_next == 3'b011) begin
          state_next         = ST_SW2_WAIT;
          sw2_hold_left_next = req.long_press_ticks;
        end
      end
      ST_SW1_WAIT: begin
        if (sw1_hold_left == '0) begin
          state_next = ST_SW1_LONG;
          ev         = EV_LONG1;
        end else begin
          sw1_hold_left_next = sw1_hold_left - HOLD_W'(1);
          if (sw1_history_next == 3'b100) begin
            state_next = ST_WAIT_PUSH;
            ev         = EV_PUSH1;
          end else if (sw1_history_next[1:0] == 2'b11 && sw2_history_next == 3'b111) begin
            state_next = ST_BOTH;
            ev         = EV_BOTH;
          end
        end
      end
      ST_SW2_WAIT: begin
        if (sw2_hold_left == '0) begin
          state_next = ST_SW2_LONG;
          ev         = EV_LONG2;
        end else begin
          sw2_hold_left_next = sw2_hold_left - HOLD_W'(1);
          if (sw2_history_next == 3'b100) begin
            state_next = ST_WAIT_PUSH;
            ev         = EV_PUSH2;
          end else if (sw2_history_next[1:0] == 2'b11 && sw1_history_next == 3'b111) begin
            state_next = ST_BOTH;
            ev         = EV_BOTH;
          end
        end
      end
      ST_SW1_LONG: begin
        if (sw1_history_next == 3'b000) begin
          state_next = ST_WAIT_PUSH;
          ev         = EV_LREL1;
        end
      end
      ST_SW2_LONG: begin
        if (sw2_history_next == 3'b000) begin
          state_next = ST_WAIT_PUSH;
          ev         = EV_LREL2;
        end
      end
      ST_BOTH: begin
        if (sw1_history_next == 3'b000 && sw2_history_next == 3'b000) begin
          state_next = ST_WAIT_PUSH;
        end
      end
      default: begin
        state_next = ST_WAIT_PUSH;
      end
    endcase
    // Nothing is reported unless a tick is actually taken.
    if (!req.tick) begin
      ev = EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_INIT;
      sw1_history   <= '0;
      sw2_history   <= '0;
      sw1_hold_left <= '0;
      sw2_hold_left <= '0;
    end else if (req.tick) begin
      state         <= state_next;
      sw1_history   <= sw1_history_next;
      sw2_history   <= sw2_history_next;
      sw1_hold_left <= sw1_hold_left_next;
      sw2_hold_left <= sw2_hold_left_next;
    end
  end

endmodule

// File: rtl/two_button_event_detector.sv
// An accepted input beat is registered in the pass stage, then in the result
// register. Throughput: one input beat per cycle while m_tready is high;
// the queue read and detector step each finish in the single pass before it.
// Reset (synchronous, active high) returns the detector to its init state,
// empties the queue by clearing its per-entry valid bits at once, and loads
// long_press_ticks with 100.
module two_button_event_detector #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] sw1_raw_level, [1] sw2_raw_level, rest zero
  input  logic        s_tuser,   // [0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [2:0] event_code, rest zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tbe_pkg::*;

  localparam int unsigned QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [QIDX_W-1:0] QIDX_LAST = QIDX_W'(QUEUE_DEPTH - 1);

  function automatic logic [QIDX_W-1:0] qidx_inc(input logic [QIDX_W-1:0] idx);
    return (idx == QIDX_LAST) ? '0 : idx + QIDX_W'(1);
  endfunction

  logic [HOLD_W-1:0]      long_press_ticks;
  logic                   cfg_write;
  logic                   in_beat;
  logic                   is_read;
  tick_req_t              tick_req;
  evt_t                   tick_ev;
  logic [2:0]             queue_mem [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] queue_valid;
  logic [QIDX_W-1:0]      queue_head;
  logic [QIDX_W-1:0]      queue_tail;
  logic                   queue_push;

  // Pass stage: memory read data and the tick event are captured together.
  logic                   p_valid;
  logic                   p_is_read;
  logic                   p_hit;
  logic [2:0]             p_mem;
  evt_t                   p_ev;
  logic                   p_move;

  logic [2:0]             out_code;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks <= LONG_PRESS_TICKS_RESET;
    end else if (cfg_write && paddr[2] == REG_LONG_PRESS_TICKS) begin
      long_press_ticks <= pwdata[HOLD_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_LONG_PRESS_TICKS) ?
                  {{(32-HOLD_W){1'b0}}, long_press_ticks} : 32'd0;

  // Input side. The pass stage may refill in the same cycle that it drains.
  assign p_move   = p_valid && (!m_tvalid || m_tready);
  assign s_tready = !p_valid || p_move;
  assign in_beat  = s_tvalid && s_tready;
  assign is_read  = s_tuser;

  assign tick_req.tick             = in_beat && !is_read;
  assign tick_req.sw1_pressed      = !s_tdata[0];
  assign tick_req.sw2_pressed      = !s_tdata[1];
  assign tick_req.long_press_ticks = long_press_ticks;

  tbe_detector u_detector (
    .clk (clk),
    .rst (rst),
    .req (tick_req),
    .ev  (tick_ev)
  );

  assign queue_push = (tick_ev != EV_NONE);

  // Event ring. A read clears the entry by dropping its valid bit.
  always_ff @(posedge clk) begin
    if (queue_push) begin
      queue_mem[queue_tail] <= tick_ev;
    end
    if (in_beat) begin
      p_mem <= queue_mem[queue_head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_valid <= '0;
      queue_head  <= '0;
      queue_tail  <= '0;
    end else begin
      if (queue_push) begin
        queue_valid[queue_tail] <= 1'b1;
        queue_tail              <= qidx_inc(queue_tail);
      end
      if (in_beat && is_read) begin
        queue_valid[queue_head] <= 1'b0;
        if (queue_head != queue_tail) begin
          queue_head <= qidx_inc(queue_head);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      p_is_read <= is_read;
      p_hit     <= queue_valid[queue_head];
      p_ev      <= tick_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (in_beat) begin
        p_valid <= 1'b1;
      end else if (p_move) begin
        p_valid <= 1'b0;
      end
      if (p_move) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      if (p_is_read) begin
        out_code <= p_hit ? p_mem : EV_NONE;
      end else begin
        out_code <= p_ev;
      end
    end
  end

  assign m_tdata = {5'd0, out_code};

endmodule
